### sv/gvb_pkg.sv
// ----------------------------------------------------------------------------
// gvb_pkg - shared types and constants for the vignette blend
// Item layout between front and back, queue status, register indexes
// and reset values.
// ----------------------------------------------------------------------------
package gvb_pkg;

    localparam int MAX_DIM_DEFAULT      = 1024;
    localparam int WEIGHT_DEPTH_DEFAULT = 1024;
    localparam int QUEUE_DEPTH          = 4;
    localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the write port
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FALLOFF_SCALE = 2'd2;

    localparam logic [10:0] FRAME_WIDTH_RST   = 11'd640;
    localparam logic [10:0] FRAME_HEIGHT_RST  = 11'd480;
    localparam logic [19:0] FALLOFF_SCALE_RST = 20'd1491;

    // offset item: distance from center and both pixels, channel 0 is blue
    typedef struct packed {
        logic signed [10:0] dy;
        logic signed [10:0] dx;
        logic [2:0][7:0]    fg;
        logic [2:0][7:0]    bg;
    } t_item;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } t_qstat;

endpackage

### sv/gvb_front.sv
// ----------------------------------------------------------------------------
// gvb_front - input stage of the vignette blend
// Accepts a pixel word, forms the signed offsets from the frame center
// and holds the item until the queue takes it.
// ----------------------------------------------------------------------------
module gvb_front #(
    parameter int MAX_DIM = gvb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [71:0]          i_data,
    input  logic [10:0]          i_frame_width,
    input  logic [10:0]          i_frame_height,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gvb_pkg::t_item       o_item
);

    localparam logic [12:0] MaxDim = 13'(MAX_DIM);

    logic                  r_valid;
    gvb_pkg::t_item        r_item;
    gvb_pkg::t_item        n_item;
    logic [10:0]           w_clamp;
    logic [10:0]           h_clamp;
    logic                  take;

    always_comb begin
        w_clamp = ({2'b00, i_frame_width} > MaxDim) ? MaxDim[10:0] : i_frame_width;
        h_clamp = ({2'b00, i_frame_height} > MaxDim) ? MaxDim[10:0] : i_frame_height;
        n_item.dy    = $signed({1'b0, i_data[9:0]}) - $signed({1'b0, h_clamp[10:1]});
        n_item.dx    = $signed({1'b0, i_data[19:10]}) - $signed({1'b0, w_clamp[10:1]});
        n_item.fg[0] = i_data[27:20];
        n_item.fg[1] = i_data[35:28];
        n_item.fg[2] = i_data[43:36];
        n_item.bg[0] = i_data[51:44];
        n_item.bg[1] = i_data[59:52];
        n_item.bg[2] = i_data[67:60];
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/gvb_queue.sv
// ----------------------------------------------------------------------------
// gvb_queue - short queue between front and back
// Lets the front keep taking words while the back is stalled.
// ----------------------------------------------------------------------------
module gvb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gvb_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output gvb_pkg::t_item o_item,
    output gvb_pkg::t_qstat o_stat
);

    localparam int PtrW = $clog2(gvb_pkg::QUEUE_DEPTH);
    localparam logic [gvb_pkg::QUEUE_CNT_W-1:0] Full =
        gvb_pkg::QUEUE_CNT_W'(gvb_pkg::QUEUE_DEPTH);

    gvb_pkg::t_item                    r_mem [gvb_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]                   r_wr_ptr;
    logic [PtrW-1:0]                   r_rd_ptr;
    logic [gvb_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                              push;
    logic                              pop;

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == Full);
    assign o_stat.empty = (r_count == '0);

    assign o_ready = !o_stat.full;
    assign o_valid = !o_stat.empty;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### sv/gvb_back.sv
// ----------------------------------------------------------------------------
// gvb_back - weight and blend pipeline
// Squares the offsets, scales the distance into a table index, looks up
// the Gaussian weight and mixes foreground and background per channel.
// ----------------------------------------------------------------------------
module gvb_back #(
    parameter int WEIGHT_TABLE_DEPTH = gvb_pkg::WEIGHT_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gvb_pkg::t_item  i_item,
    input  logic [19:0]     i_falloff_scale,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0][7:0] o_pixel
);

    localparam int          IdxW   = $clog2(WEIGHT_TABLE_DEPTH);
    localparam logic [16:0] IdxMax = 17'(WEIGHT_TABLE_DEPTH - 1);

    typedef logic [16:0] t_wrom [WEIGHT_TABLE_DEPTH];

    // a*b for Q60 values up to one, truncated
    function automatic logic [63:0] f_mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, mid;
        ah  = a >> 30;
        al  = a & 64'h3FFF_FFFF;
        bh  = b >> 30;
        bl  = b & 64'h3FFF_FFFF;
        mid = ah * bl + al * bh;
        return ah * bh + (mid >> 30) + ((al * bl) >> 60);
    endfunction

    // entry i = round(65536 * exp(-i/64)), built by repeated Q60 products
    function automatic t_wrom f_build_rom();
        logic [63:0] term, ratio, p, pos;
        t_wrom       rom;
        term  = 64'd1 << 60;
        ratio = 64'd1 << 60;
        p     = 64'd1 << 60;
        for (int k = 1; k <= 14; k++) begin
            term = term / 64'(64 * k);
            if (k[0]) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
            pos    = (p + (64'd1 << 43)) >> 44;
            rom[i] = pos[16:0];
            p      = f_mul_q60(p, ratio);
        end
        return rom;
    endfunction

    localparam t_wrom WeightRom = f_build_rom();

    logic                  en;
    logic [5:1]            r_v;
    logic [19:0]           r_dy2;
    logic [19:0]           r_dx2;
    logic [20:0]           r_d2;
    logic [40:0]           r_prod;
    logic [IdxW-1:0]       r_idx;
    logic [16:0]           r_w;
    logic [2:0][7:0]       r_fg [1:5];
    logic [2:0][7:0]       r_bg [1:5];
    logic [2:0][7:0]       r_pixel;
    logic                  r_out_v;
    logic signed [21:0]    dy_sq;
    logic signed [21:0]    dx_sq;
    logic [16:0]           idx_full;
    logic [16:0]           idx_clip;
    logic [16:0]           w_inv;
    logic [2:0][7:0]       n_pixel;
    logic [24:0]           mix [3];

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    always_comb begin
        dy_sq    = i_item.dy * i_item.dy;
        dx_sq    = i_item.dx * i_item.dx;
        idx_full = r_prod[40:24];
        idx_clip = (idx_full > IdxMax) ? IdxMax : idx_full;
        w_inv    = 17'h10000 - r_w;
        for (int c = 0; c < 3; c++) begin
            mix[c] = {9'd0, r_fg[5][c]} * {8'd0, r_w} + {9'd0, r_bg[5][c]} * {8'd0, w_inv};
            n_pixel[c] = mix[c][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[4:1], i_valid};
            r_out_v <= r_v[5];
        end
        if (en) begin
            r_dy2   <= dy_sq[19:0];
            r_dx2   <= dx_sq[19:0];
            r_d2    <= {1'b0, r_dy2} + {1'b0, r_dx2};
            r_prod  <= r_d2 * i_falloff_scale;
            r_idx   <= idx_clip[IdxW-1:0];
            r_w     <= WeightRom[r_idx];
            r_pixel <= n_pixel;
            r_fg[1] <= i_item.fg;
            r_bg[1] <= i_item.bg;
            for (int s = 2; s <= 5; s++) begin
                r_fg[s] <= r_fg[s-1];
                r_bg[s] <= r_bg[s-1];
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_pixel = r_pixel;

endmodule

### sv/gaussian_vignette_blend.sv
// ----------------------------------------------------------------------------
// gaussian_vignette_blend - Gaussian radial vignette alpha blend
// Mixes a foreground and a background BGR pixel with a weight that falls
// off with the squared distance from the frame center.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one blended word per
// clock for as long as the output side keeps taking them. An accepted word
// passes the input register, the four-entry queue and the six-stage weight
// and blend pipeline (squares, sum, falloff multiply, index clamp, weight
// table read, channel mix), whose last stage is the output register. The
// pipeline advances whenever its output register is empty or being taken;
// the queue absorbs stalls so the input keeps accepting after the output
// stops, until the queue and the input register are full. Frame size and
// falloff are to be written through the register port by the user only while
// no pixel is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gaussian_vignette_blend #(
    parameter int MAX_DIM            = gvb_pkg::MAX_DIM_DEFAULT,
    parameter int WEIGHT_TABLE_DEPTH = gvb_pkg::WEIGHT_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_row, pixel_col, fg_blue, fg_green, fg_red, bg_blue, bg_green,
    // bg_red, zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_blue, out_green, out_red
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    logic [10:0]       r_frame_width;
    logic [10:0]       r_frame_height;
    logic [19:0]       r_falloff_scale;

    logic              front_valid;
    gvb_pkg::t_item    front_item;
    logic              q_in_ready;
    logic              q_out_valid;
    gvb_pkg::t_item    q_out_item;
    gvb_pkg::t_qstat   q_stat;
    logic              back_ready;
    logic [2:0][7:0]   back_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= gvb_pkg::FRAME_WIDTH_RST;
            r_frame_height  <= gvb_pkg::FRAME_HEIGHT_RST;
            r_falloff_scale <= gvb_pkg::FALLOFF_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gvb_pkg::REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[10:0];
                gvb_pkg::REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[10:0];
                gvb_pkg::REG_FALLOFF_SCALE: r_falloff_scale <= i_cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    gvb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_data         (s_axis_tdata),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_valid        (front_valid),
        .i_ready        (q_in_ready),
        .o_item         (front_item)
    );

    gvb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (q_in_ready),
        .i_item  (front_item),
        .o_valid (q_out_valid),
        .i_ready (back_ready),
        .o_item  (q_out_item),
        .o_stat  (q_stat)
    );

    gvb_back #(
        .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_out_valid),
        .o_ready         (back_ready),
        .i_item          (q_out_item),
        .i_falloff_scale (r_falloff_scale),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_pixel         (back_pixel)
    );

    assign m_axis_tdata = back_pixel;

    // queue fill never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= gvb_pkg::QUEUE_CNT_W'(gvb_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // a held front word with a full queue must stop the input
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && q_stat.full) |-> !s_axis_tready)
        else $error("input accepted while front is blocked");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an empty queue has a zero count and offers nothing to the back end
    a_queue_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> (q_stat.count == '0) && !q_out_valid)
        else $error("queue empty flag disagrees with count");

endmodule

### sim/vignette_blend_checker.sv
// ----------------------------------------------------------------------------
// vignette_blend_checker - scoreboard for the vignette blend
// Watches the register port and both streams. Each pixel word taken in
// yields one predicted blended word. Predictions are queued in order and
// compared channel by channel with the words leaving the block.
// ----------------------------------------------------------------------------
module vignette_blend_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    // pixel_row, pixel_col, fg_blue, fg_green, fg_red, bg_blue, bg_green,
    // bg_red, zero pad
    input  logic [71:0] i_pix_word,
    input  logic        i_blend_valid,
    input  logic        i_blend_ready,
    // out_blue, out_green, out_red
    input  logic [23:0] i_blend_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int MAX_DIM      = gvb_pkg::MAX_DIM_DEFAULT;
    localparam int TABLE_DEPTH  = gvb_pkg::WEIGHT_DEPTH_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    logic [10:0]     frame_width;
    logic [10:0]     frame_height;
    logic [19:0]     falloff_scale;
    longint unsigned weight_table [TABLE_DEPTH];
    logic [23:0]     blend_q [$];
    logic [23:0]     want;
    int              reports;
    int              bad_fields;

    // exp(-i/64) in Q16, stepped down from 1.0 in Q60 by a fixed ratio
    function automatic void build_weight_table();
        longint unsigned one_q;
        longint unsigned ratio;
        longint unsigned term;
        longint unsigned p;
        longint unsigned ah;
        longint unsigned al;
        longint unsigned bh;
        longint unsigned bl;
        longint unsigned mid;
        longint unsigned mask;
        one_q = 64'd1 << 60;
        mask  = (64'd1 << 30) - 64'd1;
        term  = one_q;
        ratio = one_q;
        for (int k = 1; k <= 14; k++) begin
            term = term / longint'(64 * k);
            if (k % 2 == 1) ratio = ratio - term;
            else            ratio = ratio + term;
        end
        p = one_q;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            weight_table[i] = (p + (64'd1 << 43)) >> 44;
            ah  = p >> 30;
            al  = p & mask;
            bh  = ratio >> 30;
            bl  = ratio & mask;
            mid = ah * bl + al * bh;
            p   = ah * bh + (mid >> 30) + ((al * bl) >> 60);
        end
    endfunction

    initial build_weight_table();

    function automatic logic [23:0] blend_pixel(input logic [71:0] word);
        int              row;
        int              col;
        int              half_w;
        int              half_h;
        int              dy;
        int              dx;
        longint unsigned d2;
        longint unsigned idx;
        longint unsigned w;
        longint unsigned inv;
        longint unsigned mix;
        logic [23:0]     res;
        row    = int'(word[9:0]);
        col    = int'(word[19:10]);
        half_h = (frame_height > MAX_DIM ? MAX_DIM : int'(frame_height)) / 2;
        half_w = (frame_width > MAX_DIM ? MAX_DIM : int'(frame_width)) / 2;
        dy     = row - half_h;
        dx     = col - half_w;
        d2     = longint'(dy * dy + dx * dx);
        idx    = (d2 * falloff_scale) >> 24;
        if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
        w   = weight_table[idx];
        inv = 64'd65536 - w;
        for (int c = 0; c < 3; c++) begin
            mix = (word[20 + 8 * c +: 8] * w + word[44 + 8 * c +: 8] * inv) >> 16;
            res[8 * c +: 8] = mix[7:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_width   <= gvb_pkg::FRAME_WIDTH_RST;
            frame_height  <= gvb_pkg::FRAME_HEIGHT_RST;
            falloff_scale <= gvb_pkg::FALLOFF_SCALE_RST;
            blend_q.delete();
            o_pending     <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gvb_pkg::REG_FRAME_WIDTH:   frame_width   <= i_cfg_data[10:0];
                    gvb_pkg::REG_FRAME_HEIGHT:  frame_height  <= i_cfg_data[10:0];
                    gvb_pkg::REG_FALLOFF_SCALE: falloff_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_blend_valid && i_blend_ready) begin
                if (blend_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (reports < REPORT_LIMIT) begin
                        $display("[%0t] unexpected blended word %h", $realtime, i_blend_word);
                        reports++;
                    end
                end else begin
                    want       = blend_q.pop_front();
                    bad_fields = 0;
                    for (int c = 0; c < 3; c++) begin
                        if (want[8 * c +: 8] !== i_blend_word[8 * c +: 8]) bad_fields++;
                    end
                    if (bad_fields != 0) begin
                        o_fail_count <= o_fail_count + bad_fields;
                        if (reports < REPORT_LIMIT) begin
                            $display({"[%0t] word %0d mismatch: expected b=%0d g=%0d r=%0d,",
                                      " got b=%0d g=%0d r=%0d"},
                                     $realtime, o_checked, want[7:0], want[15:8], want[23:16],
                                     i_blend_word[7:0], i_blend_word[15:8], i_blend_word[23:16]);
                            reports++;
                        end
                    end
                    o_checked <= o_checked + 1;
                end
            end
            if (i_pix_valid && i_pix_ready) blend_q.push_back(blend_pixel(i_pix_word));
            o_pending <= blend_q.size();
        end
    end

endmodule

### sim/gaussian_vignette_blend_tb.sv
// ----------------------------------------------------------------------------
// gaussian_vignette_blend_tb - testbench for the vignette blend
// Drives pixel words through the block under several frame and falloff
// settings and flow-control patterns, including a long output hold-off.
// A separate checker predicts every blended word and compares it.
// ----------------------------------------------------------------------------
module gaussian_vignette_blend_tb;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 141;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 24;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [19:0] i_cfg_data    = '0;

    int fail_count;
    int pending_words;
    int checked_words;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int sent_words = 0;
    int settings   = 1;

    gaussian_vignette_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    vignette_blend_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (s_axis_tvalid),
        .i_pix_ready   (s_axis_tready),
        .i_pix_word    (s_axis_tdata),
        .i_blend_valid (m_axis_tvalid),
        .i_blend_ready (m_axis_tready),
        .i_blend_word  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words),
        .o_checked     (checked_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // a new hold request holds tready low for a fixed stretch
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [71:0] pack_pixel(
        input logic [9:0] row, input logic [9:0] col,
        input logic [7:0] fb, input logic [7:0] fgr, input logic [7:0] fr,
        input logic [7:0] bb, input logic [7:0] bgr, input logic [7:0] br
    );
        return {4'd0, br, bgr, bb, fr, fgr, fb, col, row};
    endfunction

    function automatic logic [71:0] random_pixel();
        logic [9:0] row;
        logic [9:0] col;
        row = 10'($urandom);
        col = 10'($urandom);
        // push some words onto the edges of the coordinate range
        if ($urandom_range(0, 9) == 0) row = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        if ($urandom_range(0, 9) == 0) col = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        return pack_pixel(row, col, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic send_pixel(input logic [71:0] word);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_words++;
    endtask

    // drop valid and hold until every predicted word has left the block
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [10:0] w, input logic [10:0] h,
                                input logic [19:0] f, input bit poke_unused);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gvb_pkg::REG_FRAME_WIDTH;
        i_cfg_data  <= {9'd0, w};
        @(posedge i_clk);
        i_cfg_index <= gvb_pkg::REG_FRAME_HEIGHT;
        i_cfg_data  <= {9'd0, h};
        @(posedge i_clk);
        i_cfg_index <= gvb_pkg::REG_FALLOFF_SCALE;
        i_cfg_data  <= f;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_index <= REG_UNUSED;
            i_cfg_data  <= 20'hFFFFF;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 50; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 50; end
            default: begin gap_pct = 33; stall_pct = 33; end
        endcase
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: center, corners, far outside the frame
        send_pixel(pack_pixel(10'd240, 10'd320, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(pack_pixel(10'd1023, 10'd1023, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
        send_pixel(pack_pixel(10'd0, 10'd1023, 8'd128, 8'd64, 8'd32, 8'd200, 8'd100, 8'd50));
        send_pixel(pack_pixel(10'd1023, 10'd0, 8'd1, 8'd2, 8'd3, 8'd254, 8'd253, 8'd252));
        send_pixel(pack_pixel(10'd250, 10'd330, 8'd170, 8'd85, 8'd255, 8'd85, 8'd170, 8'd0));

        // width above the maximum, zero height, zero falloff, unused index
        wait_idle();
        program_regs(11'd2047, 11'd0, 20'd0, 1'b1);
        send_pixel(pack_pixel(10'd0, 10'd0, 8'd17, 8'd34, 8'd51, 8'd200, 8'd201, 8'd202));
        send_pixel(pack_pixel(10'd1023, 10'd1023, 8'd255, 8'd128, 8'd0, 8'd0, 8'd127, 8'd255));
        send_pixel(pack_pixel(10'd512, 10'd700, 8'd90, 8'd91, 8'd92, 8'd10, 8'd11, 8'd12));

        // width of one, full height, largest falloff
        wait_idle();
        program_regs(11'd1, 11'd1024, 20'hFFFFF, 1'b0);
        send_pixel(pack_pixel(10'd0, 10'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(10'd1, 10'd1, 8'd200, 8'd150, 8'd100, 8'd50, 8'd25, 8'd5));
        send_pixel(pack_pixel(10'd512, 10'd0, 8'd33, 8'd66, 8'd99, 8'd222, 8'd111, 8'd0));

        wait_idle();
        program_regs(11'd0, 11'd2047, 20'd16384, 1'b0);
        repeat (3) send_pixel(random_pixel());

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: program_regs(gvb_pkg::FRAME_WIDTH_RST, gvb_pkg::FRAME_HEIGHT_RST,
                                gvb_pkg::FALLOFF_SCALE_RST, 1'b0);
                1: program_regs(11'd1024, 11'd1024, 20'd65535, 1'b0);
                2: program_regs(11'd2047, 11'd2047, 20'hFFFFF, 1'b0);
                3: program_regs(11'd1, 11'd1, 20'd0, 1'b1);
                4: program_regs(11'd0, 11'd0, 20'($urandom_range(0, 131071)), 1'b0);
                5: program_regs(11'($urandom), 11'($urandom), 20'($urandom_range(0, 131071)),
                                1'b0);
                6: program_regs(11'($urandom), 11'($urandom), 20'($urandom), 1'b0);
                default: program_regs(11'($urandom_range(1, 1024)),
                                      11'($urandom_range(1, 1024)),
                                      20'($urandom_range(0, 262143)), 1'b0);
            endcase
            set_idling(p % 4);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) begin
                    // odd phases: stall the output and keep feeding; even: drain first
                    if (p % 2 == 1) hold_seq <= hold_seq + 1;
                    else            wait_idle();
                end
                send_pixel(random_pixel());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d pixel words over %0d register settings with idle, stall, hold-off.",
                 sent_words, settings);
        $display("Compared %0d blended words channel by channel.", checked_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/gvb_pkg.sv
sv/gvb_front.sv
sv/gvb_queue.sv
sv/gvb_back.sv
sv/gaussian_vignette_blend.sv
sim/vignette_blend_checker.sv
sim/gaussian_vignette_blend_tb.sv
